FILE: rtl/gld_pkg.sv
package gld_pkg;
	localparam int MAX_CODE_WIDTH_DEF = 12;
	localparam int MIN_SIZE_WIDTH     = 4;
	localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_PULL  = 2'd1,
		KIND_START = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_PIXEL   = 3'd0,
		ST_NEED    = 3'd1,
		ST_CLEAR   = 3'd2,
		ST_EOI     = 3'd3,
		ST_EXHAUST = 3'd4,
		ST_INVALID = 3'd5
	} status_t;

	typedef struct packed {
		logic start;
		logic push;
		logic take_code;
		logic walk_load_code;
		logic walk_load_prev;
		logic push_prev_first;
		logic walk_step;
		logic walk_final;
		logic add_entry;
		logic commit_prev;
		logic dict_clear;
		logic set_terminal;
		logic [2:0] terminal_code;
		logic pop;
	} gld_cmd_t;

	typedef struct packed {
		logic    stack_nonempty;
		logic    terminal;
		logic    enough_bits;
		logic    input_ended;
		logic    code_is_clear;
		logic    code_is_eoi;
		logic    code_known;
		logic    code_kwkwk;
		logic    walk_more;
		logic    prev_valid;
		logic    push_ok;
		status_t terminal_status;
	} gld_sts_t;
endpackage

FILE: rtl/gld_if.sv
interface gld_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, kind, data_byte, last_byte, input ready);
	modport sink (input valid, kind, data_byte, last_byte, output ready);
endinterface

interface gld_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] pixel;
	modport source (output valid, status, pixel, input ready);
	modport sink (input valid, status, pixel, output ready);
endinterface

interface gld_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] min_code_size;
	modport source (output valid, min_code_size, input ready);
	modport sink (input valid, min_code_size, output ready);
endinterface

FILE: rtl/gld_ram.sv
module gld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/gld_datapath.sv
module gld_datapath
	import gld_pkg::*;
#(
	parameter int MAX_CODE_WIDTH = MAX_CODE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gld_cmd_t                  cmd,
	input  logic [MIN_SIZE_WIDTH-1:0] min_size,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	output gld_sts_t                  sts,
	output logic [7:0]                pop_data
);
	localparam int CW    = MAX_CODE_WIDTH;
	localparam int BUFW  = CW + 8;
	localparam int HELDW = $clog2(BUFW + 1);
	localparam int DICT  = 1 << CW;
	localparam int WW    = $clog2(CW + 1);

	logic [BUFW-1:0]  buf_q;
	logic [HELDW-1:0] held_q;
	logic [WW-1:0]    width_q;
	logic [CW:0]      free_q;
	logic [CW-1:0]    prev_q;
	logic             prev_valid_q;
	logic [7:0]       prev_first_q;
	logic [CW:0]      depth_q;
	logic             ended_q;
	status_t          term_q;
	logic [3:0]       amin_q;
	logic [CW-1:0]    code_q;
	logic [CW-1:0]    walk_q;
	logic [CW:0]      steps_q;
	logic [7:0]       first_q;

	logic [3:0]    min_clamped;
	logic [CW:0]   clear_code;
	logic [CW:0]   first_entry;
	logic [CW-1:0] cur_code;
	logic [CW-1:0] pref_rd;
	logic [7:0]    suf_rd;
	logic [CW-1:0] walk_next;
	logic          stk_we;
	logic [7:0]    stk_wdata;
	logic [CW-1:0] dict_raddr;

	assign min_clamped = (min_size < 4'd2) ? 4'd2 : (min_size > 4'd8) ? 4'd8 : min_size;
	assign clear_code  = (CW+1)'(1) << amin_q;
	assign first_entry = clear_code + (CW+1)'(2);
	assign cur_code    = CW'(buf_q & ((BUFW'(1) << width_q) - BUFW'(1)));
	assign walk_next   = cmd.walk_load_code ? code_q : prev_q;
	// dictionary address follows the entry being walked
	assign dict_raddr  = (cmd.walk_load_code || cmd.walk_load_prev) ? walk_next : walk_q;

	gld_ram #(.WIDTH(CW), .DEPTH(DICT)) u_prefix (
		.clk(clk), .we(cmd.add_entry && free_q < (CW+1)'(DICT)),
		.waddr(free_q[CW-1:0]), .wdata(prev_q), .raddr(dict_raddr), .rdata(pref_rd));
	gld_ram #(.WIDTH(8), .DEPTH(DICT)) u_suffix (
		.clk(clk), .we(cmd.add_entry && free_q < (CW+1)'(DICT)),
		.waddr(free_q[CW-1:0]), .wdata(cmd.walk_final ? walk_q[7:0] : first_q),
		.raddr(dict_raddr), .rdata(suf_rd));

	// stack write: suffix during walk, root byte at end, previous first for KwKwK
	always_comb begin
		stk_we    = 1'b0;
		stk_wdata = suf_rd;
		if (cmd.push_prev_first) begin
			stk_we = 1'b1; stk_wdata = prev_first_q;
		end else if (cmd.walk_step) begin
			stk_we = 1'b1; stk_wdata = suf_rd;
		end else if (cmd.walk_final) begin
			stk_we = 1'b1; stk_wdata = walk_q[7:0];
		end
	end

	gld_ram #(.WIDTH(8), .DEPTH(DICT)) u_stack (
		.clk(clk), .we(stk_we && depth_q < (CW+1)'(DICT)),
		.waddr(depth_q[CW-1:0]), .wdata(stk_wdata),
		.raddr(CW'(depth_q - (CW+1)'(1))), .rdata(pop_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0; held_q <= '0; amin_q <= MIN_SIZE_RESET;
			width_q <= WW'(MIN_SIZE_RESET + 4'd1);
			free_q <= ((CW+1)'(1) << MIN_SIZE_RESET) + (CW+1)'(2);
			prev_q <= '0; prev_valid_q <= 1'b0; prev_first_q <= '0;
			depth_q <= '0; ended_q <= 1'b0; term_q <= ST_PIXEL;
			code_q <= '0; walk_q <= '0; steps_q <= '0; first_q <= '0;
		end else begin
			if (cmd.start) begin
				amin_q <= min_clamped; buf_q <= '0; held_q <= '0;
				width_q <= WW'(min_clamped + 4'd1);
				free_q <= ((CW+1)'(1) << min_clamped) + (CW+1)'(2);
				prev_valid_q <= 1'b0; prev_q <= '0; prev_first_q <= '0;
				depth_q <= '0; ended_q <= 1'b0; term_q <= ST_PIXEL;
			end
			if (cmd.push) begin
				buf_q   <= buf_q | (BUFW'(data_byte) << held_q);
				held_q  <= held_q + HELDW'(8);
				ended_q <= last_byte;
			end
			if (cmd.take_code) begin
				code_q <= cur_code;
				buf_q  <= buf_q >> width_q;
				held_q <= held_q - HELDW'(width_q);
			end
			if (cmd.dict_clear) begin
				width_q <= WW'(amin_q + 4'd1);
				free_q <= first_entry;
				prev_valid_q <= 1'b0;
			end
			if (cmd.set_terminal) term_q <= status_t'(cmd.terminal_code);
			if (cmd.walk_load_code || cmd.walk_load_prev) begin
				walk_q <= walk_next; steps_q <= '0;
			end
			if (cmd.walk_step) begin
				walk_q <= pref_rd; steps_q <= steps_q + (CW+1)'(1);
			end
			if (cmd.walk_final) first_q <= walk_q[7:0];
			if (stk_we && depth_q < (CW+1)'(DICT)) depth_q <= depth_q + (CW+1)'(1);
			if (cmd.pop) depth_q <= depth_q - (CW+1)'(1);
			if (cmd.add_entry && free_q < (CW+1)'(DICT)) begin
				free_q <= free_q + (CW+1)'(1);
				if (free_q + (CW+1)'(1) == ((CW+1)'(1) << width_q) && width_q < WW'(CW))
					width_q <= width_q + WW'(1);
			end
			if (cmd.commit_prev) begin
				prev_q <= code_q; prev_valid_q <= 1'b1;
				prev_first_q <= cmd.walk_final ? walk_q[7:0] : first_q;
			end
		end
	end

	always_comb begin
		sts.stack_nonempty  = depth_q != '0;
		sts.terminal        = term_q != ST_PIXEL;
		sts.terminal_status = term_q;
		sts.enough_bits     = held_q >= HELDW'(width_q);
		sts.input_ended     = ended_q;
		sts.code_is_clear   = {1'b0, code_q} == clear_code;
		sts.code_is_eoi     = {1'b0, code_q} == clear_code + (CW+1)'(1);
		sts.code_known      = {1'b0, code_q} < free_q;
		sts.code_kwkwk      = {1'b0, code_q} == free_q && prev_valid_q;
		sts.walk_more       = {1'b0, walk_q} >= first_entry && steps_q < (CW+1)'(DICT);
		sts.prev_valid      = prev_valid_q;
		sts.push_ok         = !sts.terminal && !ended_q && (held_q <= HELDW'(BUFW - 8));
	end
endmodule

FILE: rtl/gld_ctrl.sv
module gld_ctrl
	import gld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  kind_t      kind,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [2:0] out_status,
	output logic       out_take_pop,
	input  gld_sts_t   sts,
	output gld_cmd_t   cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_WALK_WAIT, S_WALK, S_POP_WAIT, S_OUT
	} state_t;

	state_t     state_q;
	logic       pop_q;
	logic [2:0] status_q;
	logic       out_valid_q;
	logic       accept;

	assign in_ready     = state_q == S_IDLE && !out_valid_q;
	assign out_valid    = out_valid_q;
	assign out_status   = status_q;
	assign out_take_pop = pop_q;
	assign accept       = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_START: cmd.start = 1'b1;
						KIND_PUSH:  cmd.push = sts.push_ok;
						KIND_PULL: begin
							if (!sts.stack_nonempty && !sts.terminal) begin
								if (!sts.enough_bits) begin
									if (sts.input_ended) begin
										cmd.set_terminal = 1'b1; cmd.terminal_code = ST_EXHAUST;
									end
								end else cmd.take_code = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_DECODE: begin
				if (sts.code_is_clear) cmd.dict_clear = 1'b1;
				else if (sts.code_is_eoi) begin
					cmd.set_terminal = 1'b1; cmd.terminal_code = ST_EOI;
				end else if (sts.code_known) cmd.walk_load_code = 1'b1;
				else if (sts.code_kwkwk) begin
					cmd.push_prev_first = 1'b1; cmd.walk_load_prev = 1'b1;
				end else begin
					cmd.set_terminal = 1'b1; cmd.terminal_code = ST_INVALID;
				end
			end
			S_WALK: begin
				if (sts.walk_more) begin
					cmd.walk_step = 1'b1;
				end else begin
					cmd.walk_final  = 1'b1;
					cmd.add_entry   = sts.prev_valid;
					cmd.commit_prev = 1'b1;
				end
			end
			S_POP_WAIT: cmd.pop = 1'b0;
			S_OUT: if (out_ready && pop_q) cmd.pop = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid_q <= 1'b0; pop_q <= 1'b0;
			status_q <= ST_PIXEL;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && kind == KIND_PULL) begin
						if (sts.stack_nonempty) begin
							state_q <= S_POP_WAIT;
						end else if (sts.terminal) begin
							status_q <= sts.terminal_status; pop_q <= 1'b0;
							out_valid_q <= 1'b1; state_q <= S_OUT;
						end else if (!sts.enough_bits) begin
							status_q <= sts.input_ended ? ST_EXHAUST : ST_NEED;
							pop_q <= 1'b0; out_valid_q <= 1'b1; state_q <= S_OUT;
						end else state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (sts.code_is_clear) begin
						status_q <= ST_CLEAR; pop_q <= 1'b0; out_valid_q <= 1'b1; state_q <= S_OUT;
					end else if (sts.code_is_eoi) begin
						status_q <= ST_EOI; pop_q <= 1'b0; out_valid_q <= 1'b1; state_q <= S_OUT;
					end else if (sts.code_known || sts.code_kwkwk) begin
						state_q <= S_WALK_WAIT;
					end else begin
						status_q <= ST_INVALID; pop_q <= 1'b0; out_valid_q <= 1'b1; state_q <= S_OUT;
					end
				end
				S_WALK_WAIT: state_q <= S_WALK;
				S_WALK: begin
					if (sts.walk_more) state_q <= S_WALK_WAIT;
					else state_q <= S_POP_WAIT;
				end
				S_POP_WAIT: begin
					status_q <= ST_PIXEL; pop_q <= 1'b1; out_valid_q <= 1'b1; state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0; pop_q <= 1'b0; state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/gif_lzw_decoder_core.sv
// GIF LZW decoder core.
// Channels: req (kind/data_byte/last_byte), rsp (status/pixel), cfg (min_code_size).
// A request is accepted when req.valid and req.ready are both high.
// Push (kind 0) and start (kind 2) requests give no response; each pull
// (kind 1) gives exactly one response: a pixel or a status code.
// A pull that pops a stacked pixel goes through S_POP_WAIT for the registered
// stack read and then presents its response in S_OUT. A status-only pull
// (need input, exhausted, repeated terminal) has its response valid in the
// cycle after acceptance; clear, end and invalid codes are first checked in
// S_DECODE. A pull that decodes a new code walks the prefix chain one
// dictionary entry at a time through S_WALK_WAIT and S_WALK (registered RAM
// read), stacking the string, and answers with its first pixel; the later L-1
// pixels of a string of length L then come out on later pulls, one per pull.
// min_code_size is latched at reset (8) and at each start request.
// Reset clears all control state; dictionary and stack RAMs are not
// cleared, since only written entries are ever read.
// While rsp is stalled the core holds its response and takes no request.
module gif_lzw_decoder_core
	import gld_pkg::*;
#(
	parameter int MAX_CODE_WIDTH = MAX_CODE_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	gld_in_if.sink    req,
	gld_out_if.source rsp,
	gld_cfg_if.sink   cfg
);
	logic [3:0] min_q;
	gld_cmd_t   cmd;
	gld_sts_t   sts;
	logic [7:0] pop_data;
	logic [2:0] status;
	logic       take_pop;

	// register write always accepted
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_SIZE_RESET;
		end else if (cfg.valid) begin
			min_q <= cfg.min_code_size;
		end
	end

	gld_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .kind(kind_t'(req.kind)),
		.out_ready(rsp.ready), .out_valid(rsp.valid), .out_status(status),
		.out_take_pop(take_pop), .sts(sts), .cmd(cmd));

	gld_datapath #(.MAX_CODE_WIDTH(MAX_CODE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .min_size(min_q),
		.data_byte(req.data_byte), .last_byte(req.last_byte),
		.sts(sts), .pop_data(pop_data));

	assign rsp.status = status;
	assign rsp.pixel  = take_pop ? pop_data : 8'd0;

	a_no_req_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("request taken while response pending");
	a_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_PIXEL) |-> rsp.pixel == 8'd0)
		else $error("status response carries pixel");
	a_rsp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready) |=> !rsp.valid) else $error("response repeated");
endmodule
